// ----- rtl/core/bba_pkg.sv -----
// bba_pkg: shared types and codes of the bitmap block allocator
// no dependencies; used by bba_scan and bitmap_block_allocator
package bba_pkg;

    localparam int IDX_FIELD_W = 12;
    localparam int CNT_FIELD_W = 13;
    localparam int CMD_FIELD_W = 1;
    localparam int STS_FIELD_W = 2;

    localparam logic [CNT_FIELD_W-1:0] TOTAL_RESET = 13'd4096;

    localparam logic [CMD_FIELD_W-1:0] CMD_ALLOC = 1'b0;
    localparam logic [CMD_FIELD_W-1:0] CMD_FREE  = 1'b1;

    localparam logic [STS_FIELD_W-1:0] STS_OK          = 2'd0;
    localparam logic [STS_FIELD_W-1:0] STS_FULL        = 2'd1;
    localparam logic [STS_FIELD_W-1:0] STS_DOUBLE_FREE = 2'd2;
    localparam logic [STS_FIELD_W-1:0] STS_RANGE       = 2'd3;

    typedef struct packed {
        logic [CMD_FIELD_W-1:0] command;
        logic [IDX_FIELD_W-1:0] block_index;
    } req_beat_t;

    typedef struct packed {
        logic [STS_FIELD_W-1:0] status;
        logic [IDX_FIELD_W-1:0] result_index;
        logic [CNT_FIELD_W-1:0] free_blocks;
    } rsp_beat_t;

    // outcome of one word search
    typedef struct packed {
        logic found;
        logic last;
    } scan_flags_t;

endpackage

// ----- rtl/core/bba_ram.sv -----
// bba_ram: generic single-write, single-read ram with registered read data
// no dependencies
module bba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/bba_scan.sv -----
// bba_scan: lowest clear bit of one bitmap word, limited to indices below the total
// depends on bba_pkg
module bba_scan #(
    parameter int SCAN_WIDTH = 32,
    parameter int LW         = 13
) (
    input  logic [SCAN_WIDTH-1:0]         word,
    input  logic [LW-1:0]                 base,
    input  logic [LW-1:0]                 lim,
    output logic [$clog2(SCAN_WIDTH)-1:0] pos,
    output bba_pkg::scan_flags_t          flags
);

    localparam int BIT_W = $clog2(SCAN_WIDTH);

    logic [LW-1:0]         rem;
    logic                  any_left;
    logic [SCAN_WIDTH-1:0] in_range;
    logic [SCAN_WIDTH-1:0] avail;

    always_comb
    begin
        any_left = lim > base;
        rem      = lim - base;
        for (int b = 0; b < SCAN_WIDTH; b++)
        begin
            in_range[b] = any_left && (LW'(b) < rem);
        end
        avail = ~word & in_range;

        // priority encoder, lowest bit wins
        pos = '0;
        for (int b = SCAN_WIDTH - 1; b >= 0; b--)
        begin
            if (avail[b])
            begin
                pos = BIT_W'(b);
            end
        end

        flags.found = |avail;
        flags.last  = (base + LW'(SCAN_WIDTH)) >= lim;
    end

endmodule

// ----- rtl/core/bitmap_block_allocator.sv -----
// bitmap_block_allocator: top level, sequencer, occupancy ram and used counter
// depends on bba_pkg, bba_ram, bba_scan
//
// first-fit block allocator over a one-bit-per-block occupancy bitmap held in a ram
// of NUM_BLOCKS/SCAN_WIDTH words. one request beat is taken at a time; req_stall is high
// while a request is in progress. an allocate reads the bitmap one word per cycle from
// word 0 and stops at the first word with a clear bit below the effective total
// (total_blocks saturated at NUM_BLOCKS); each word read is issued to the ram's
// registered read port and checked by the word search unit once the data returns.
// a free goes through read, test and write back, and response; an out-of-range free
// goes straight to the response. the response beat sits in an output register, so it
// may wait on rsp_stall while the block is already idle again. the bitmap starts
// all-free after reset through per-word valid flops, with no clearing pass.
// total_blocks is written through cfg_we/cfg_wdata; the user must write it only while
// the block is idle, as the block itself does not enforce this.
module bitmap_block_allocator #(
    parameter int NUM_BLOCKS = 4096,
    parameter int SCAN_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [bba_pkg::CNT_FIELD_W-1:0]      cfg_wdata,
    input  logic                                 req_valid,
    output logic                                 req_stall,
    input  bba_pkg::req_beat_t                   req,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output bba_pkg::rsp_beat_t                   rsp
);

    localparam int WORDS   = (NUM_BLOCKS + SCAN_WIDTH - 1) / SCAN_WIDTH;
    localparam int WADDR_W = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int BIT_W   = $clog2(SCAN_WIDTH);
    localparam int CNT_W   = $clog2(NUM_BLOCKS + 1);
    localparam int LW      = WADDR_W + BIT_W + 1;

    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(WORDS - 1);

    // sequencer states
    localparam logic [2:0] ST_IDLE     = 3'd0;
    localparam logic [2:0] ST_ALLOC    = 3'd1;
    localparam logic [2:0] ST_FREE_RD  = 3'd2;
    localparam logic [2:0] ST_FREE_CHK = 3'd3;
    localparam logic [2:0] ST_RESP     = 3'd4;

    logic [2:0]                         state_reg, state_next;
    logic [bba_pkg::CNT_FIELD_W-1:0]    total_reg;
    logic [CNT_W-1:0]                   used_reg, used_next;
    logic [bba_pkg::IDX_FIELD_W-1:0]    idx_reg, idx_next;
    logic [WADDR_W-1:0]                 scan_reg, scan_next;
    logic [WADDR_W-1:0]                 chk_reg, chk_next;
    logic                               pend_reg, pend_next;
    logic [bba_pkg::STS_FIELD_W-1:0]    sts_reg, sts_next;
    logic [bba_pkg::IDX_FIELD_W-1:0]    res_reg, res_next;
    logic [WORDS-1:0]                   vld_reg;
    logic                               rd_vld_reg;
    logic                               out_valid_reg;
    bba_pkg::rsp_beat_t                 out_reg;

    logic [CNT_W-1:0]                   lim;
    logic [WADDR_W-1:0]                 rd_addr;
    logic [SCAN_WIDTH-1:0]              ram_q;
    logic [SCAN_WIDTH-1:0]              rd_word;
    logic                               wr_en;
    logic [SCAN_WIDTH-1:0]              wr_word;
    logic [BIT_W-1:0]                   hit_pos;
    bba_pkg::scan_flags_t               hit;
    logic [LW-1:0]                      chk_base;
    logic [BIT_W-1:0]                   free_bit;
    logic                               req_take;
    logic                               out_load;
    logic [CNT_W-1:0]                   free_cnt;

    // effective total, saturated at the bitmap size
    assign lim = (32'(total_reg) > 32'(NUM_BLOCKS)) ? CNT_W'(NUM_BLOCKS) : CNT_W'(total_reg);

    assign req_stall = (state_reg != ST_IDLE);
    assign req_take  = req_valid && !req_stall;
    assign out_load  = (state_reg == ST_RESP) && (!out_valid_reg || !rsp_stall);

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    // never-written words read as all free
    assign rd_word  = rd_vld_reg ? ram_q : '0;
    assign chk_base = {1'b0, chk_reg, {BIT_W{1'b0}}};
    assign free_bit = idx_reg[BIT_W-1:0];
    assign rd_addr  = (state_reg == ST_ALLOC) ? scan_reg : WADDR_W'(idx_reg >> BIT_W);

    // free count after the beat, saturated at zero
    assign free_cnt = (lim > used_reg) ? (lim - used_reg) : '0;

    bba_ram #(
        .WIDTH (SCAN_WIDTH),
        .DEPTH (WORDS)
    ) u_bitmap (
        .clk   (clk),
        .we    (wr_en),
        .waddr (chk_reg),
        .wdata (wr_word),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    bba_scan #(
        .SCAN_WIDTH (SCAN_WIDTH),
        .LW         (LW)
    ) u_scan (
        .word  (rd_word),
        .base  (chk_base),
        .lim   (LW'(lim)),
        .pos   (hit_pos),
        .flags (hit)
    );

    always_comb
    begin
        state_next = state_reg;
        used_next  = used_reg;
        idx_next   = idx_reg;
        scan_next  = scan_reg;
        chk_next   = chk_reg;
        pend_next  = pend_reg;
        sts_next   = sts_reg;
        res_next   = res_reg;
        wr_en      = 1'b0;
        wr_word    = rd_word;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_take)
                begin
                    idx_next  = req.block_index;
                    scan_next = '0;
                    pend_next = 1'b0;
                    sts_next  = bba_pkg::STS_OK;
                    res_next  = '0;
                    if (req.command == bba_pkg::CMD_ALLOC)
                    begin
                        state_next = ST_ALLOC;
                    end
                    else if (32'(req.block_index) >= 32'(lim))
                    begin
                        sts_next   = bba_pkg::STS_RANGE;
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_FREE_RD;
                    end
                end
            end

            ST_ALLOC:
            begin
                // one word read issued per cycle, checked in the cycle after it is issued
                chk_next  = scan_reg;
                pend_next = 1'b1;
                if (scan_reg != LAST_WORD)
                begin
                    scan_next = scan_reg + WADDR_W'(1);
                end
                if (pend_reg)
                begin
                    if (hit.found)
                    begin
                        wr_en      = 1'b1;
                        wr_word    = rd_word | (SCAN_WIDTH'(1) << hit_pos);
                        used_next  = used_reg + CNT_W'(1);
                        res_next   = bba_pkg::IDX_FIELD_W'(chk_base + LW'(hit_pos));
                        chk_next   = chk_reg;
                        state_next = ST_RESP;
                    end
                    else if (hit.last)
                    begin
                        sts_next   = bba_pkg::STS_FULL;
                        state_next = ST_RESP;
                    end
                end
            end

            ST_FREE_RD:
            begin
                chk_next   = rd_addr;
                state_next = ST_FREE_CHK;
            end

            ST_FREE_CHK:
            begin
                if (!rd_word[free_bit])
                begin
                    sts_next = bba_pkg::STS_DOUBLE_FREE;
                end
                else
                begin
                    wr_en    = 1'b1;
                    wr_word  = rd_word & ~(SCAN_WIDTH'(1) << free_bit);
                    res_next = idx_reg;
                    if (used_reg != '0)
                    begin
                        used_next = used_reg - CNT_W'(1);
                    end
                end
                state_next = ST_RESP;
            end

            ST_RESP:
            begin
                if (out_load)
                begin
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            total_reg     <= bba_pkg::TOTAL_RESET;
            used_reg      <= '0;
            pend_reg      <= 1'b0;
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            pend_reg  <= pend_next;
            if (cfg_we)
            begin
                total_reg <= cfg_wdata;
            end
            if (wr_en)
            begin
                vld_reg[chk_reg] <= 1'b1;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and datapath registers
    always_ff @(posedge clk)
    begin
        idx_reg    <= idx_next;
        scan_reg   <= scan_next;
        chk_reg    <= chk_next;
        sts_reg    <= sts_next;
        res_reg    <= res_next;
        rd_vld_reg <= vld_reg[rd_addr];
        if (out_load)
        begin
            out_reg.status       <= sts_reg;
            out_reg.result_index <= res_reg;
            out_reg.free_blocks  <= bba_pkg::CNT_FIELD_W'(free_cnt);
        end
    end

`ifndef SYNTHESIS
    // a taken request always leaves idle
    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        req_take |=> (state_reg != ST_IDLE))
        else $error("sequencer stayed idle after a request beat");

    // used count can never pass the bitmap size
    a_used_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        used_reg <= CNT_W'(NUM_BLOCKS))
        else $error("used block count exceeds bitmap size");

    // error responses carry index zero
    a_err_zero_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_reg.status != bba_pkg::STS_OK)) |-> (out_reg.result_index == '0))
        else $error("error response with nonzero index");

    // the bitmap is written only while a request is being decided
    a_write_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |=> (state_reg == ST_RESP))
        else $error("bitmap write not followed by response");
`endif

endmodule
